>>> hdl/u2fval_pkg.sv
// ----------------------------------------------------------------------------
// U2F request validator package
// Shared types, opcode and status constants and the verdict-to-status mapping
// used by the capture, check and top-level modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u2fval_pkg;

  // Default width of the request byte counter.
  localparam int unsigned LengthBitsDefault = 16;

  // Width used for length arithmetic: a 16-bit Lc plus a small offset.
  localparam int unsigned CalcBits = 18;

  // Number of captured header bytes and the key-handle length positions.
  localparam int unsigned HeaderBytes    = 7;
  localparam int unsigned ShortHandlePos = 69;
  localparam int unsigned ExtHandlePos   = 71;

  // U2F instruction codes.
  localparam logic [7:0] InsRegister     = 8'h01;
  localparam logic [7:0] InsAuthenticate = 8'h02;
  localparam logic [7:0] InsVersion      = 8'h03;

  // AUTHENTICATE control byte values.
  localparam logic [7:0] P1CheckOnly  = 8'h07;
  localparam logic [7:0] P1Enforce    = 8'h03;
  localparam logic [7:0] P1DontEnforce = 8'h08;

  // REGISTER payload: challenge plus application id.
  localparam logic [15:0] PayloadSize = 16'd64;

  // ISO status words.
  localparam logic [15:0] SwOk          = 16'h0000;
  localparam logic [15:0] SwWrongLength = 16'h6700;
  localparam logic [15:0] SwClaNotSupp  = 16'h6E00;
  localparam logic [15:0] SwInsNotSupp  = 16'h6D00;
  localparam logic [15:0] SwWrongData   = 16'h6A80;

  typedef enum logic [2:0] {
    VERDICT_OK           = 3'd0,
    VERDICT_WRONG_LENGTH = 3'd1,
    VERDICT_CLA          = 3'd2,
    VERDICT_INS          = 3'd3,
    VERDICT_WRONG_DATA   = 3'd4
  } verdict_e;

  // Captured request contents, as seen after the current byte is applied.
  typedef struct packed {
    logic                              overflow;
    logic [7:0]                        short_handle;
    logic [7:0]                        ext_handle;
    logic [HeaderBytes-1:0][7:0]       header;
  } req_view_t;

  // Result of one request check.
  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] status_word;
    logic        needs_presence;
  } result_t;

  function automatic logic [15:0] status_of(verdict_e v);
    logic [15:0] sw;
    case (v)
      VERDICT_OK:           sw = SwOk;
      VERDICT_WRONG_LENGTH: sw = SwWrongLength;
      VERDICT_CLA:          sw = SwClaNotSupp;
      VERDICT_INS:          sw = SwInsNotSupp;
      VERDICT_WRONG_DATA:   sw = SwWrongData;
      default:              sw = SwOk;
    endcase
    return sw;
  endfunction

endpackage

`default_nettype wire

>>> hdl/u2fval_capture.sv
// ----------------------------------------------------------------------------
// U2F request validator byte capture
// Counts request bytes, keeps the header bytes and both key-handle length
// bytes, and flags a request that runs past the counter range.
// ----------------------------------------------------------------------------
`default_nettype none

module u2fval_capture #(
  parameter int unsigned LENGTH_BITS = u2fval_pkg::LengthBitsDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   last_byte_i,
  output u2fval_pkg::req_view_t       view_o,
  output logic [LENGTH_BITS-1:0]      length_o
);

  localparam logic [LENGTH_BITS-1:0] CountMax = {LENGTH_BITS{1'b1}};

  logic [LENGTH_BITS-1:0]   count_q, count_d;
  logic                     ovf_q, ovf_d;
  logic [u2fval_pkg::HeaderBytes-1:0][7:0] hdr_q, hdr_d;
  logic [7:0]               skh_q, skh_d;
  logic [7:0]               ekh_q, ekh_d;

  // State after the current byte, before the end-of-request clear.
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    hdr_d   = hdr_q;
    skh_d   = skh_q;
    ekh_d   = ekh_q;
    if (!ovf_q) begin
      for (int i = 0; i < int'(u2fval_pkg::HeaderBytes); i++) begin
        if (count_q == LENGTH_BITS'(i)) begin
          hdr_d[i] = data_byte_i;
        end
      end
      if (count_q == LENGTH_BITS'(u2fval_pkg::ShortHandlePos)) begin
        skh_d = data_byte_i;
      end
      if (count_q == LENGTH_BITS'(u2fval_pkg::ExtHandlePos)) begin
        ekh_d = data_byte_i;
      end
      if (count_q == CountMax) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + LENGTH_BITS'(1);
      end
    end
  end

  assign view_o.overflow     = ovf_d;
  assign view_o.short_handle = skh_d;
  assign view_o.ext_handle   = ekh_d;
  assign view_o.header       = hdr_d;
  assign length_o            = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  // Captured bytes need no reset; checks only read bytes inside the request.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hdr_q <= hdr_d;
      skh_q <= skh_d;
      ekh_q <= ekh_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/u2fval_judge.sv
// ----------------------------------------------------------------------------
// U2F request validator checks
// Decides the verdict, status word and user-presence flag of one complete
// request from its length and captured bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module u2fval_judge #(
  parameter int unsigned LENGTH_BITS = u2fval_pkg::LengthBitsDefault
) (
  input  u2fval_pkg::req_view_t       view_i,
  input  wire logic [LENGTH_BITS-1:0] length_i,
  output u2fval_pkg::result_t         result_o
);

  localparam int unsigned CW = u2fval_pkg::CalcBits;

  logic [CW-1:0] len_x;
  logic [CW-1:0] lc_ext, lc_short, lc;
  logic          ext_sel, env_ok, p1_valid;
  logic [7:0]    ins, p1, kh;
  u2fval_pkg::verdict_e verdict;

  assign ins    = view_i.header[1];
  assign p1     = view_i.header[2];
  assign len_x  = CW'(length_i);

  // Extended Lc form needs seven bytes and a zero first length byte.
  assign ext_sel  = (length_i >= LENGTH_BITS'(7)) && (view_i.header[4] == 8'h00);
  assign lc_ext   = CW'({view_i.header[5], view_i.header[6]});
  assign lc_short = CW'(view_i.header[4]);
  assign lc       = ext_sel ? lc_ext : lc_short;
  assign kh       = ext_sel ? view_i.ext_handle : view_i.short_handle;

  always_comb begin
    if (ext_sel) begin
      env_ok = (len_x == lc_ext + CW'(7)) || (len_x == lc_ext + CW'(9));
    end else begin
      env_ok = (len_x == lc_short + CW'(5)) || (len_x == lc_short + CW'(6));
    end
  end

  assign p1_valid = (p1 == u2fval_pkg::P1CheckOnly) || (p1 == u2fval_pkg::P1Enforce) ||
                    (p1 == u2fval_pkg::P1DontEnforce);

  always_comb begin
    verdict = u2fval_pkg::VERDICT_OK;
    if (view_i.overflow || (length_i < LENGTH_BITS'(4))) begin
      verdict = u2fval_pkg::VERDICT_WRONG_LENGTH;
    end else if (view_i.header[0] != 8'h00) begin
      verdict = u2fval_pkg::VERDICT_CLA;
    end else if (ins == u2fval_pkg::InsVersion) begin
      // Bare header or a single trailing byte is always accepted.
      if ((length_i != LENGTH_BITS'(4)) && (length_i != LENGTH_BITS'(5)) &&
          (!env_ok || (lc != '0))) begin
        verdict = u2fval_pkg::VERDICT_WRONG_LENGTH;
      end
    end else if (length_i < LENGTH_BITS'(7)) begin
      verdict = u2fval_pkg::VERDICT_WRONG_LENGTH;
    end else if (ins == u2fval_pkg::InsRegister) begin
      if (!env_ok || (lc != CW'(u2fval_pkg::PayloadSize))) begin
        verdict = u2fval_pkg::VERDICT_WRONG_LENGTH;
      end
    end else if (ins == u2fval_pkg::InsAuthenticate) begin
      if (!env_ok) begin
        verdict = u2fval_pkg::VERDICT_WRONG_LENGTH;
      end else if (!p1_valid) begin
        verdict = u2fval_pkg::VERDICT_WRONG_DATA;
      end else if ((lc < CW'(u2fval_pkg::PayloadSize) + CW'(1)) ||
                   (lc != CW'(u2fval_pkg::PayloadSize) + CW'(1) + CW'(kh))) begin
        verdict = u2fval_pkg::VERDICT_WRONG_LENGTH;
      end
    end else begin
      verdict = u2fval_pkg::VERDICT_INS;
    end
  end

  assign result_o.verdict        = verdict;
  assign result_o.status_word    = u2fval_pkg::status_of(verdict);
  assign result_o.needs_presence =
      ((length_i >= LENGTH_BITS'(2)) && (ins == u2fval_pkg::InsRegister)) ||
      ((length_i >= LENGTH_BITS'(3)) && (ins == u2fval_pkg::InsAuthenticate) &&
       (p1 == u2fval_pkg::P1Enforce));

endmodule

`default_nettype wire

>>> hdl/u2f_apdu_request_validator_core.sv
// ----------------------------------------------------------------------------
// U2F request APDU validator core
// Streams one request APDU byte by byte and returns a single verdict, ISO
// status word and user-presence flag when the last byte has been seen.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  request  | in_valid_i, in_ready_o, data_byte_i,      | in
//           | last_byte_i                               |
//  verdict  | out_valid_o, out_ready_i, verdict_o,      | out
//           | status_word_o, needs_presence_o           |
//
// One request byte is taken per cycle unless the request side stalls. A byte
// first waits in the input register, then updates the byte counter and
// capture registers; a last byte also loads the result register at that edge,
// which holds the verdict until it is taken. Reset clears the counter, the
// overflow flag and both valid flags. The request side stalls only when a
// last byte waits in the input register while the previous verdict has not
// been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module u2f_apdu_request_validator_core #(
  parameter int unsigned LENGTH_BITS = u2fval_pkg::LengthBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       verdict_o,
  output logic [15:0]      status_word_o,
  output logic             needs_presence_o
);

  // Input register.
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_last_q;
  logic       a_adv;

  // Result register.
  logic                r_valid_q;
  u2fval_pkg::result_t r_result_q;

  u2fval_pkg::req_view_t  view;
  logic [LENGTH_BITS-1:0] length;
  u2fval_pkg::result_t    result;

  // The held byte moves on unless it closes a request whose verdict has
  // nowhere to go because the previous one is still waiting.
  assign a_adv      = a_valid_q && !(a_last_q && r_valid_q && !out_ready_i);
  assign in_ready_o = !a_valid_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_byte_q <= data_byte_i;
      a_last_q <= last_byte_i;
    end
  end

  u2fval_capture #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (a_adv),
    .data_byte_i (a_byte_q),
    .last_byte_i (a_last_q),
    .view_o      (view),
    .length_o    (length)
  );

  u2fval_judge #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_judge (
    .view_i   (view),
    .length_i (length),
    .result_o (result)
  );

  // A verdict is loaded on the last byte of a request and held until the
  // downstream side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (a_adv && a_last_q) begin
      r_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      r_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_last_q) begin
      r_result_q <= result;
    end
  end

  assign out_valid_o      = r_valid_q;
  assign verdict_o        = r_result_q.verdict;
  assign status_word_o    = r_result_q.status_word;
  assign needs_presence_o = r_result_q.needs_presence;

  // A verdict never carries a status word that disagrees with it on success.
  a_ok_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((verdict_o == u2fval_pkg::VERDICT_OK) == (status_word_o == 16'h0000)))
    else $error("verdict and status word disagree");

  // A last byte that moves on always produces a verdict in the next cycle.
  a_last_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && a_last_q) |=> out_valid_o)
    else $error("last byte did not produce a verdict");

  // A blocked last byte must stall the request side.
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_last_q && r_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("request side not stalled behind a pending verdict");

endmodule

`default_nettype wire
